// ----- design/hslc_pkg.sv -----
// Shared types, fixed-point constants and helpers for the HSL colourize pipeline.
`timescale 1ns / 1ps

package hslc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIX_W     = FRAC_BITS + 1;
    localparam int QUOT_W    = FRAC_BITS + 2;
    localparam int RECIP_W   = FRAC_BITS + 2;
    localparam int PROD_W    = FRAC_BITS + 7;
    localparam int CORR_W    = FRAC_BITS + 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef logic [FIX_W-1:0]  fix_t;
    typedef logic [QUOT_W-1:0] quot_t;

    localparam fix_t FIX_ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam fix_t FIX_HALF       = {2'b01, {(FRAC_BITS - 1){1'b0}}};
    localparam fix_t FIX_THIRD      = FIX_W'((64'd1 << FRAC_BITS) / 64'd3);
    localparam fix_t FIX_TWO_THIRDS = FIX_W'((64'd2 << FRAC_BITS) / 64'd3);

    // Constant divisors and their scaled reciprocals
    localparam int LUM_DIV = 510;
    localparam int SAT_DIV = 100;
    localparam int HUE_DIV = 360;
    localparam int PCT_DIV = 100;

    localparam int LUM_GUARD = 10;
    localparam int SAT_GUARD = 8;
    localparam int HUE_GUARD = 10;
    localparam int PCT_GUARD = PROD_W;

    localparam logic [RECIP_W-1:0] LUM_RECIP =
        RECIP_W'((64'd1 << (FRAC_BITS + LUM_GUARD)) / LUM_DIV);
    localparam logic [RECIP_W-1:0] SAT_RECIP =
        RECIP_W'((64'd1 << (FRAC_BITS + SAT_GUARD)) / SAT_DIV);
    localparam logic [RECIP_W-1:0] HUE_RECIP =
        RECIP_W'((64'd1 << (FRAC_BITS + HUE_GUARD)) / HUE_DIV);
    localparam logic [RECIP_W-1:0] PCT_RECIP =
        RECIP_W'((64'd1 << PCT_GUARD) / PCT_DIV);

    localparam logic [6:0] SAT_MAX = 7'd100;
    localparam logic [8:0] HUE_MAX = 9'd360;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HUE        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MASK_EN    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MASK_RED   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_MASK_GREEN = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_MASK_BLUE  = CFG_IDX_W'(6);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [8:0]        hue_degrees;
        logic [6:0]        saturation_percent;
        logic signed [7:0] lightness_change_percent;
        logic              mask_enable;
        pixel_t            mask;
    } cfg_t;

    typedef struct packed {
        pixel_t pix;
        logic   hit;
        fix_t   l;
        fix_t   s;
        fix_t   h;
    } hsl_t;

    // Fix up a reciprocal estimate that is at most one below the true quotient
    function automatic quot_t fix_correct(input logic [CORR_W-1:0] num,
                                          input quot_t             est,
                                          input logic [CORR_W-1:0] divisor);
        logic [CORR_W-1:0] rem;
        rem = num - CORR_W'(est) * divisor;
        if (rem >= divisor)
        begin
            fix_correct = est + QUOT_W'(1);
        end
        else
        begin
            fix_correct = est;
        end
    endfunction

endpackage

// ----- design/hslc_front.sv -----
// Front stages: mask match, lightness of the source pixel, saturation and hue fractions.
`timescale 1ns / 1ps

module hslc_front
    import hslc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  cfg_t   cfg,
    input  logic   in_valid,
    input  pixel_t in_pix,
    output logic   out_valid,
    output hsl_t   out_hsl
);

    typedef struct packed {
        pixel_t     pix;
        logic       hit;
        logic [8:0] sum;
    } st_a_t;

    typedef struct packed {
        pixel_t     pix;
        logic       hit;
        logic [8:0] sum;
        logic [6:0] sat;
        logic [8:0] hue;
        quot_t      l_est;
        quot_t      s_est;
        quot_t      h_est;
    } st_b_t;

    logic [2:0] vld_reg, vld_next;
    st_a_t      a_reg, a_next;
    st_b_t      b_reg, b_next;
    hsl_t       c_reg, c_next;

    logic [7:0] mx_rg, mn_rg, mx, mn;
    logic [LUM_GUARD+QUOT_W-1:0] l_prod;
    logic [SAT_GUARD+QUOT_W-1:0] s_prod;
    logic [HUE_GUARD+QUOT_W-1:0] h_prod;
    quot_t l_q, s_q, h_q;

    assign vld_next = {vld_reg[1:0], in_valid};

    // Stage A: register pixel, mask compare, max + min
    always_comb
    begin
        mx_rg      = (in_pix.red > in_pix.green) ? in_pix.red : in_pix.green;
        mx         = (mx_rg > in_pix.blue) ? mx_rg : in_pix.blue;
        mn_rg      = (in_pix.red < in_pix.green) ? in_pix.red : in_pix.green;
        mn         = (mn_rg < in_pix.blue) ? mn_rg : in_pix.blue;
        a_next.pix = in_pix;
        a_next.hit = cfg.mask_enable && (in_pix == cfg.mask);
        a_next.sum = {1'b0, mx} + {1'b0, mn};
    end

    // Stage B: limit saturation and hue, reciprocal estimates of the three quotients
    always_comb
    begin
        b_next.pix = a_reg.pix;
        b_next.hit = a_reg.hit;
        b_next.sum = a_reg.sum;
        b_next.sat = (cfg.saturation_percent >= SAT_MAX) ? SAT_MAX : cfg.saturation_percent;
        b_next.hue = (cfg.hue_degrees >= HUE_MAX) ? HUE_MAX : cfg.hue_degrees;
        l_prod = (LUM_GUARD + QUOT_W)'(a_reg.sum) * (LUM_GUARD + QUOT_W)'(LUM_RECIP);
        s_prod = (SAT_GUARD + QUOT_W)'(b_next.sat) * (SAT_GUARD + QUOT_W)'(SAT_RECIP);
        h_prod = (HUE_GUARD + QUOT_W)'(b_next.hue) * (HUE_GUARD + QUOT_W)'(HUE_RECIP);
        b_next.l_est = l_prod[LUM_GUARD +: QUOT_W];
        b_next.s_est = s_prod[SAT_GUARD +: QUOT_W];
        b_next.h_est = h_prod[HUE_GUARD +: QUOT_W];
    end

    // Stage C: correct each estimate by at most one
    always_comb
    begin
        l_q = fix_correct(CORR_W'(b_reg.sum) << FRAC_BITS, b_reg.l_est, CORR_W'(LUM_DIV));
        s_q = fix_correct(CORR_W'(b_reg.sat) << FRAC_BITS, b_reg.s_est, CORR_W'(SAT_DIV));
        h_q = fix_correct(CORR_W'(b_reg.hue) << FRAC_BITS, b_reg.h_est, CORR_W'(HUE_DIV));
        c_next.pix = b_reg.pix;
        c_next.hit = b_reg.hit;
        c_next.l   = l_q[FIX_W-1:0];
        c_next.s   = s_q[FIX_W-1:0];
        c_next.h   = h_q[FIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_hsl   = c_reg;

endmodule

// ----- design/hslc_lum_adjust.sv -----
// Lightness adjustment stages: scale lightness toward white or black by a percentage.
`timescale 1ns / 1ps

module hslc_lum_adjust
    import hslc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  cfg_t cfg,
    input  logic in_valid,
    input  hsl_t in_hsl,
    output logic out_valid,
    output hsl_t out_hsl
);

    typedef enum logic [1:0] {ADJ_KEEP, ADJ_UP, ADJ_DOWN, ADJ_ZERO} adj_t;

    typedef struct packed {
        hsl_t              base;
        adj_t              mode;
        logic [PROD_W-1:0] prod;
    } st_d_t;

    typedef struct packed {
        hsl_t              base;
        adj_t              mode;
        logic [PROD_W-1:0] prod;
        quot_t             q_est;
    } st_e_t;

    logic [2:0] vld_reg, vld_next;
    st_d_t      d_reg, d_next;
    st_e_t      e_reg, e_next;
    hsl_t       f_reg, f_next;

    logic signed [7:0]             chg;
    logic [8:0]                    k;
    logic [6:0]                    coef;
    fix_t                          opnd;
    logic [PCT_GUARD+QUOT_W-1:0]   p_prod;
    quot_t                         q;
    logic [QUOT_W:0]               l_sum;

    assign vld_next = {vld_reg[1:0], in_valid};

    // Stage D: pick coefficient and operand, multiply
    always_comb
    begin
        chg  = cfg.lightness_change_percent;
        k    = {chg[7], chg} + 9'd100;
        coef = '0;
        opnd = '0;
        d_next.mode = ADJ_KEEP;
        if (chg[7])
        begin
            if (k[8] || (k == 9'd0))
            begin
                d_next.mode = ADJ_ZERO;
            end
            else
            begin
                d_next.mode = ADJ_DOWN;
                coef        = k[6:0];
                opnd        = in_hsl.l;
            end
        end
        else if (chg != 8'sd0)
        begin
            d_next.mode = ADJ_UP;
            coef        = chg[6:0];
            opnd        = FIX_ONE - in_hsl.l;
        end
        d_next.base = in_hsl;
        d_next.prod = PROD_W'(coef) * PROD_W'(opnd);
    end

    // Stage E: reciprocal estimate of prod / 100
    always_comb
    begin
        p_prod = (PCT_GUARD + QUOT_W)'(d_reg.prod) * (PCT_GUARD + QUOT_W)'(PCT_RECIP);
        e_next.base  = d_reg.base;
        e_next.mode  = d_reg.mode;
        e_next.prod  = d_reg.prod;
        e_next.q_est = p_prod[PCT_GUARD +: QUOT_W];
    end

    // Stage F: correct quotient, apply and limit to one
    always_comb
    begin
        q = fix_correct(CORR_W'(e_reg.prod), e_reg.q_est, CORR_W'(PCT_DIV));
        case (e_reg.mode)
            ADJ_UP:   l_sum = (QUOT_W + 1)'(e_reg.base.l) + (QUOT_W + 1)'(q);
            ADJ_DOWN: l_sum = (QUOT_W + 1)'(q);
            ADJ_ZERO: l_sum = '0;
            ADJ_KEEP: l_sum = (QUOT_W + 1)'(e_reg.base.l);
            default:  l_sum = (QUOT_W + 1)'(e_reg.base.l);
        endcase
        f_next   = e_reg.base;
        f_next.l = (l_sum > (QUOT_W + 1)'(FIX_ONE)) ? FIX_ONE : l_sum[FIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            e_reg <= e_next;
            f_reg <= f_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_hsl   = f_reg;

endmodule

// ----- design/hslc_chroma.sv -----
// HSL to RGB stages: v1/v2, per-channel hue segments, rounding and the output register.
`timescale 1ns / 1ps

module hslc_chroma
    import hslc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  cfg_t   cfg,
    input  logic   in_valid,
    input  hsl_t   in_hsl,
    output logic   out_valid,
    output pixel_t out_pix
);

    typedef enum logic [1:0] {SEG_RISE, SEG_TOP, SEG_FALL, SEG_BASE} seg_t;

    typedef struct packed {
        seg_t seg;
        fix_t opnd;
    } chan_t;

    typedef struct packed {
        pixel_t pix;
        logic   hit;
        fix_t   l;
        fix_t   s;
        fix_t   h;
        fix_t   ls;
    } st_g_t;

    typedef struct packed {
        pixel_t      pix;
        logic        hit;
        fix_t        l;
        fix_t        v1;
        fix_t        v2;
        chan_t [2:0] ch;
    } st_h_t;

    typedef struct packed {
        pixel_t pix;
        logic   hit;
        fix_t   l;
        fix_t   [2:0] val;
    } st_j_t;

    logic [4:0] vld_reg, vld_next;
    st_g_t      g_reg, g_next;
    st_h_t      h_reg, h_next;
    st_h_t      i_reg, i_next;   // opnd holds the scaled span once past stage I
    st_j_t      j_reg, j_next;
    pixel_t     k_reg, k_next;

    logic [2*FIX_W-1:0] m_prod;
    logic [FIX_W:0]     v2_w, v1_w, t0_w;
    fix_t               t0, t2;
    fix_t               span;
    logic [2*FIX_W-1:0] s_prod [3];
    logic [FIX_W+7:0]   x_chan [3];
    logic [FIX_W+7:0]   x_grey;
    logic [7:0]         chan [3];
    logic [7:0]         grey;

    function automatic chan_t hue_seg(input fix_t t);
        logic [FIX_W+2:0] t6, t2x, t3x, one_x, two_x, d6;
        fix_t  d;
        chan_t r;
        one_x = (FIX_W + 3)'(FIX_ONE);
        two_x = one_x << 1;
        t6    = (FIX_W + 3)'(t) * (FIX_W + 3)'(6);
        t2x   = (FIX_W + 3)'(t) << 1;
        t3x   = (FIX_W + 3)'(t) * (FIX_W + 3)'(3);
        d     = FIX_TWO_THIRDS - t;
        d6    = (FIX_W + 3)'(d) * (FIX_W + 3)'(6);
        if (t6 < one_x)
        begin
            r.seg  = SEG_RISE;
            r.opnd = t6[FIX_W-1:0];
        end
        else if (t2x < one_x)
        begin
            r.seg  = SEG_TOP;
            r.opnd = '0;
        end
        else if (t3x < two_x)
        begin
            r.seg  = SEG_FALL;
            r.opnd = d6[FIX_W-1:0];
        end
        else
        begin
            r.seg  = SEG_BASE;
            r.opnd = '0;
        end
        hue_seg = r;
    endfunction

    assign vld_next = {vld_reg[3:0], in_valid};

    // Stage G: product S * L
    always_comb
    begin
        m_prod    = (2 * FIX_W)'(in_hsl.l) * (2 * FIX_W)'(in_hsl.s);
        g_next.pix = in_hsl.pix;
        g_next.hit = in_hsl.hit;
        g_next.l   = in_hsl.l;
        g_next.s   = in_hsl.s;
        g_next.h   = in_hsl.h;
        g_next.ls  = m_prod[FRAC_BITS +: FIX_W];
    end

    // Stage H: v1, v2 and the segment of each channel hue
    always_comb
    begin
        if (g_reg.l < FIX_HALF)
        begin
            v2_w = (FIX_W + 1)'(g_reg.l) + (FIX_W + 1)'(g_reg.ls);
        end
        else
        begin
            v2_w = (FIX_W + 1)'(g_reg.l) + (FIX_W + 1)'(g_reg.s) - (FIX_W + 1)'(g_reg.ls);
        end
        v1_w = {g_reg.l, 1'b0} - v2_w;

        // Wrap channel hues into 0..ONE
        t0_w = (FIX_W + 1)'(g_reg.h) + (FIX_W + 1)'(FIX_THIRD);
        t0   = (t0_w > (FIX_W + 1)'(FIX_ONE)) ? t0_w[FIX_W-1:0] - FIX_ONE : t0_w[FIX_W-1:0];
        t2   = (g_reg.h < FIX_THIRD) ? g_reg.h + FIX_ONE - FIX_THIRD : g_reg.h - FIX_THIRD;

        h_next.pix   = g_reg.pix;
        h_next.hit   = g_reg.hit;
        h_next.l     = g_reg.l;
        h_next.v1    = v1_w[FIX_W-1:0];
        h_next.v2    = v2_w[FIX_W-1:0];
        h_next.ch[0] = hue_seg(t0);
        h_next.ch[1] = hue_seg(g_reg.h);
        h_next.ch[2] = hue_seg(t2);
    end

    // Stage I: scale the span by each channel operand
    always_comb
    begin
        span   = h_reg.v2 - h_reg.v1;
        i_next = h_reg;
        for (int n = 0; n < 3; n++)
        begin
            s_prod[n] = (2 * FIX_W)'(span) * (2 * FIX_W)'(h_reg.ch[n].opnd);
            i_next.ch[n].opnd = s_prod[n][FRAC_BITS +: FIX_W];
        end
    end

    // Stage J: channel value from its segment
    always_comb
    begin
        j_next.pix = i_reg.pix;
        j_next.hit = i_reg.hit;
        j_next.l   = i_reg.l;
        for (int n = 0; n < 3; n++)
        begin
            case (i_reg.ch[n].seg)
                SEG_RISE: j_next.val[n] = i_reg.v1 + i_reg.ch[n].opnd;
                SEG_FALL: j_next.val[n] = i_reg.v1 + i_reg.ch[n].opnd;
                SEG_TOP:  j_next.val[n] = i_reg.v2;
                default:  j_next.val[n] = i_reg.v1;
            endcase
        end
    end

    // Stage K: round colour channels to 8 bits (grey is truncated), pick mask, grey or colour
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            x_chan[n] = (FIX_W + 8)'(j_reg.val[n]) * (FIX_W + 8)'(255)
                        + (FIX_W + 8)'(FIX_HALF);
            chan[n]   = x_chan[n][FRAC_BITS + 8] ? 8'hFF : x_chan[n][FRAC_BITS +: 8];
        end
        x_grey = (FIX_W + 8)'(j_reg.l) * (FIX_W + 8)'(255);
        grey   = x_grey[FRAC_BITS + 8] ? 8'hFF : x_grey[FRAC_BITS +: 8];

        if (j_reg.hit)
        begin
            k_next = j_reg.pix;
        end
        else if (cfg.saturation_percent == 7'd0)
        begin
            k_next.red   = grey;
            k_next.green = grey;
            k_next.blue  = grey;
        end
        else
        begin
            k_next.red   = chan[0];
            k_next.green = chan[1];
            k_next.blue  = chan[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg <= g_next;
            h_reg <= h_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_pix   = k_reg;

endmodule

// ----- design/hsl_colourize_pixel_core.sv -----
// Top level of the HSL colourize pixel core: configuration registers and pipeline flow control.
`timescale 1ns / 1ps

// One RGB888 pixel enters on the s_axis stream and one recoloured pixel leaves on m_axis.
// Hue and saturation are replaced by the configured values and the HSL lightness is moved
// toward white or black by a signed percentage; a pixel equal to the mask colour passes
// unchanged while the mask is enabled.
// Registers are written through cfg_we / cfg_index / cfg_wdata, one per clock, with no
// read-back; write them only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver does not stall. The core is an 11-stage
// register pipeline (front, lightness adjust and HSL-to-RGB sections).
// All stages advance together: while m_axis holds a pixel that is not taken, s_axis_tready
// drops and the whole pipeline holds, so nothing is lost or repeated.
// Reset clears the stage valid bits and the configuration registers (all zero).

module hsl_colourize_pixel_core
    import hslc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // in_red, in_green, in_blue
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // out_red, out_green, out_blue
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t   cfg_reg, cfg_next;
    logic   en;
    pixel_t in_pix;
    pixel_t out_pix;
    logic   front_valid, lum_valid;
    hsl_t   front_hsl, lum_hsl;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HUE:        cfg_next.hue_degrees              = cfg_wdata[8:0];
                REG_SATURATION: cfg_next.saturation_percent       = cfg_wdata[6:0];
                REG_LIGHTNESS:  cfg_next.lightness_change_percent = cfg_wdata[7:0];
                REG_MASK_EN:    cfg_next.mask_enable              = cfg_wdata[0];
                REG_MASK_RED:   cfg_next.mask.red                 = cfg_wdata[7:0];
                REG_MASK_GREEN: cfg_next.mask.green               = cfg_wdata[7:0];
                REG_MASK_BLUE:  cfg_next.mask.blue                = cfg_wdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance every stage unless the output holds a pixel that is not taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign in_pix.red   = s_axis_tdata[7:0];
    assign in_pix.green = s_axis_tdata[15:8];
    assign in_pix.blue  = s_axis_tdata[23:16];

    hslc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_pix    (in_pix),
        .out_valid (front_valid),
        .out_hsl   (front_hsl)
    );

    hslc_lum_adjust u_lum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (front_valid),
        .in_hsl    (front_hsl),
        .out_valid (lum_valid),
        .out_hsl   (lum_hsl)
    );

    hslc_chroma u_chroma (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (lum_valid),
        .in_hsl    (lum_hsl),
        .out_valid (m_axis_tvalid),
        .out_pix   (out_pix)
    );

    assign m_axis_tdata = {out_pix.blue, out_pix.green, out_pix.red};

endmodule

// ----- verif/hsl_colourize_pixel_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hsl_colourize_pixel_core: directed and random pixels against a shadow predictor.

module hsl_colourize_pixel_core_tb;
    import hslc_pkg::*;

    localparam longint UNIT            = longint'(1) << FRAC_BITS;
    localparam longint UNIT_HALF       = UNIT / 2;
    localparam longint UNIT_THIRD      = UNIT / 3;
    localparam longint UNIT_TWO_THIRDS = (2 * UNIT) / 3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PIPE_LATENCY  = 11;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS  = 140;
    localparam int BURST_PIXELS  = 170;

    // Index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;   // in_red, in_green, in_blue
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // out_red, out_green, out_blue
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Shadow copy of the configuration registers
    logic [8:0]        shadow_hue      = '0;
    logic [6:0]        shadow_sat      = '0;
    logic signed [7:0] shadow_light    = '0;
    logic              shadow_mask_on  = 1'b0;
    pixel_t            shadow_mask     = '0;

    pixel_t expected_pixels[$];
    int     pixels_sent     = 0;
    int     results_checked = 0;
    int     mismatches      = 0;
    int     settings_count  = 0;
    int     cycle_count     = 0;
    bit     idling_on       = 1'b1;
    int     gap_pct         = 0;

    hsl_colourize_pixel_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("[hsl_colourize_pixel_core] ERROR");
            $finish;
        end
    end

    function automatic pixel_t rgb(input int r, input int g, input int b);
        pixel_t p;
        p.red   = 8'(r);
        p.green = 8'(g);
        p.blue  = 8'(b);
        return p;
    endfunction

    function automatic pixel_t from_bus(input logic [23:0] d);
        return rgb(int'(d[7:0]), int'(d[15:8]), int'(d[23:16]));
    endfunction

    // Piecewise hue ramp of the HSL-to-RGB conversion
    function automatic longint hue_ramp(input longint lo, input longint hi, input longint t);
        longint span;
        longint d;
        span = hi - lo;
        if (span < 0)
            span = 0;
        if (t < 0)
            t += UNIT;
        if (t > UNIT)
            t -= UNIT;
        if (6 * t < UNIT)
            return lo + ((span * 6 * t) >>> FRAC_BITS);
        if (2 * t < UNIT)
            return hi;
        if (3 * t < 2 * UNIT)
        begin
            d = UNIT_TWO_THIRDS - t;
            if (d < 0)
                d = 0;
            return lo + ((span * d * 6) >>> FRAC_BITS);
        end
        return lo;
    endfunction

    // Round half up to an 8-bit channel and saturate
    function automatic logic [7:0] to_level(input longint v);
        longint x;
        x = 255 * v + UNIT_HALF;
        if (x < 0)
            return 8'd0;
        x = x >>> FRAC_BITS;
        if (x > 255)
            return 8'd255;
        return 8'(x);
    endfunction

    function automatic pixel_t recolour(input pixel_t src);
        longint hi_ch;
        longint lo_ch;
        longint lum;
        longint keep;
        longint sat_fx;
        longint hue_fx;
        longint v_hi;
        longint v_lo;
        longint grey;
        pixel_t res;
        if (shadow_mask_on && src == shadow_mask)
            return src;
        hi_ch = (src.red > src.green) ? longint'(src.red) : longint'(src.green);
        hi_ch = (hi_ch > longint'(src.blue)) ? hi_ch : longint'(src.blue);
        lo_ch = (src.red < src.green) ? longint'(src.red) : longint'(src.green);
        lo_ch = (lo_ch < longint'(src.blue)) ? lo_ch : longint'(src.blue);
        lum = ((hi_ch + lo_ch) << FRAC_BITS) / 510;
        if (shadow_light > 0)
        begin
            lum = lum + (longint'(shadow_light) * (UNIT - lum)) / 100;
        end
        else if (shadow_light < 0)
        begin
            keep = 100 + longint'(shadow_light);
            lum  = (keep <= 0) ? 0 : (lum * keep) / 100;
        end
        if (lum < 0)
            lum = 0;
        if (lum > UNIT)
            lum = UNIT;
        // No saturation: plain grey, truncated
        if (shadow_sat == 0)
        begin
            grey = (lum * 255) >>> FRAC_BITS;
            if (grey > 255)
                grey = 255;
            res.red   = 8'(grey);
            res.green = 8'(grey);
            res.blue  = 8'(grey);
            return res;
        end
        sat_fx = (shadow_sat >= 100) ? UNIT : (longint'(shadow_sat) << FRAC_BITS) / 100;
        hue_fx = (shadow_hue >= 360) ? UNIT : (longint'(shadow_hue) << FRAC_BITS) / 360;
        if (lum < UNIT_HALF)
            v_hi = (lum * (UNIT + sat_fx)) >>> FRAC_BITS;
        else
            v_hi = lum + sat_fx - ((sat_fx * lum) >>> FRAC_BITS);
        v_lo = 2 * lum - v_hi;
        res.red   = to_level(hue_ramp(v_lo, v_hi, hue_fx + UNIT_THIRD));
        res.green = to_level(hue_ramp(v_lo, v_hi, hue_fx));
        res.blue  = to_level(hue_ramp(v_lo, v_hi, hue_fx - UNIT_THIRD));
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_pixels.push_back(recolour(from_bus(s_axis_tdata)));
            pixels_sent++;
        end
    end

    task automatic report_channel(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = from_bus(m_axis_tdata);
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = expected_pixels.pop_front();
                report_channel("out_red", want.red, got.red);
                report_channel("out_green", want.green, got.green);
                report_channel("out_blue", want.blue, got.blue);
                results_checked++;
            end
        end
    end

    // Receiver: ready stretches broken by short stall bursts while idling_on is set
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (idling_on)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_HUE:        shadow_hue = val[8:0];
            REG_SATURATION: shadow_sat = val[6:0];
            REG_LIGHTNESS:  shadow_light = val[7:0];
            REG_MASK_EN:    shadow_mask_on = val[0];
            REG_MASK_RED:   shadow_mask.red = val[7:0];
            REG_MASK_GREEN: shadow_mask.green = val[7:0];
            REG_MASK_BLUE:  shadow_mask.blue = val[7:0];
            default:        ;
        endcase
    endtask

    task automatic apply_settings(input int hue, input int sat, input int light,
                                  input bit mask_on, input pixel_t mask);
        write_reg(REG_HUE, CFG_DATA_W'(hue));
        write_reg(REG_SATURATION, CFG_DATA_W'(sat));
        write_reg(REG_LIGHTNESS, CFG_DATA_W'(light & 255));
        write_reg(REG_MASK_EN, CFG_DATA_W'(mask_on));
        write_reg(REG_MASK_RED, CFG_DATA_W'(mask.red));
        write_reg(REG_MASK_GREEN, CFG_DATA_W'(mask.green));
        write_reg(REG_MASK_BLUE, CFG_DATA_W'(mask.blue));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_count++;
    endtask

    // Hold the pixel until it transfers; tvalid stays high for a following pixel
    task automatic send_pixel(input pixel_t p);
        if (idling_on && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.blue, p.green, p.red};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        wait_drained();
    endtask

    function automatic pixel_t pick_pixel();
        pixel_t p;
        logic [7:0] g;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                p = shadow_mask;
            end
            2:
            begin
                p = shadow_mask ^ (24'd1 << $urandom_range(0, 23));
            end
            3:
            begin
                g = 8'($urandom);
                p = rgb(int'(g), int'(g), int'(g));
            end
            4:
            begin
                p = rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                        $urandom_range(0, 1) * 255);
            end
            default:
            begin
                p = 24'($urandom);
            end
        endcase
        return p;
    endfunction

    task automatic random_settings();
        int hue;
        int sat;
        int light;
        pixel_t mask;
        case ($urandom_range(0, 9))
            0:       hue = 0;
            1:       hue = 360;
            2:       hue = $urandom_range(361, 511);
            default: hue = $urandom_range(0, 359);
        endcase
        case ($urandom_range(0, 9))
            0:       sat = 0;
            1:       sat = 100;
            2:       sat = $urandom_range(101, 127);
            default: sat = $urandom_range(1, 99);
        endcase
        case ($urandom_range(0, 11))
            0:       light = -100;
            1:       light = 100;
            2:       light = -$urandom_range(101, 128);
            3:       light = $urandom_range(101, 127);
            4:       light = 0;
            default: light = $urandom_range(0, 198) - 99;
        endcase
        case ($urandom_range(0, 5))
            0:       mask = rgb(0, 0, 0);
            1:       mask = rgb(255, 255, 255);
            default: mask = 24'($urandom);
        endcase
        apply_settings(hue, sat, light, 1'($urandom_range(0, 1)), mask);
    endtask

    // Registers at their reset values: zero saturation gives grey, mask off
    task automatic check_reset_state();
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(255, 0, 128));
        end_burst();
    endtask

    task automatic check_directed_cases();
        // Top hue (360), out-of-range saturation and lightness with the mask enabled
        apply_settings(360, 127, 127, 1'b1, rgb(10, 20, 30));
        send_pixel(rgb(10, 20, 30));
        send_pixel(rgb(10, 20, 31));
        send_pixel(rgb(255, 255, 255));
        end_burst();

        // Mask colour matches but mask is off; darkest possible change
        write_reg(REG_SPARE, '1);
        apply_settings(511, 100, -128, 1'b0, rgb(0, 0, 0));
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(200, 100, 50));
        end_burst();

        apply_settings(0, 1, -100, 1'b0, rgb(255, 255, 255));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(128, 64, 32));
        end_burst();

        apply_settings(120, 50, 100, 1'b0, rgb(0, 0, 0));
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(17, 200, 90));
        end_burst();

        apply_settings(240, 100, -1, 1'b1, rgb(255, 0, 255));
        send_pixel(rgb(255, 0, 255));
        send_pixel(rgb(255, 1, 255));
        end_burst();

        apply_settings(60, 100, 0, 1'b0, rgb(0, 0, 0));
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(127, 128, 0));
        end_burst();
    endtask

    task automatic check_random_settings();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_settings();
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 40;
            endcase
            repeat (PHASE_PIXELS) send_pixel(pick_pixel());
            end_burst();
        end
    endtask

    // Full rate on both sides, no stalls
    task automatic check_back_to_back();
        idling_on = 1'b0;
        gap_pct   = 0;
        random_settings();
        repeat (BURST_PIXELS) send_pixel(pick_pixel());
        end_burst();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_state();
        check_directed_cases();
        check_random_settings();
        check_back_to_back();

        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
        end
        $display("Sent %0d pixels under %0d register settings, compared %0d results",
                 pixels_sent, settings_count, results_checked);
        $display("Mismatches found: %0d", mismatches);
        if (mismatches == 0)
        begin
            $display("[hsl_colourize_pixel_core] OK");
        end
        else
        begin
            $display("[hsl_colourize_pixel_core] ERROR");
        end
        $finish;
    end

endmodule
